FILE: hw/rtl/arce_pkg.sv
package arce_pkg;

   localparam int POS_W       = 16;   // run coordinates and lengths
   localparam int CLIP_W      = 16;   // clip and clean lengths
   localparam int CUR_W       = POS_W + 1;
   localparam int CAP_W       = 10;
   localparam int WORD_LEN_W  = 28;
   localparam int NWORDS      = 5;
   localparam int WIDX_W      = 3;
   localparam int IN_W        = 128;
   localparam int OUT_W       = 120;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [QCNT_W-1:0] QDEPTH_C = QCNT_W'(QDEPTH);
   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(1023);

   typedef enum logic [3:0] {
      OP_M = 4'd0,
      OP_I = 4'd1,
      OP_D = 4'd2,
      OP_S = 4'd4,
      OP_H = 4'd5
   } cigar_op_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_PAST_END = 2'd1,
      ERR_FULL     = 2'd2,
      ERR_BACK     = 2'd3
   } err_type;

   typedef struct packed {
      cigar_op_type     op;
      logic [CUR_W-1:0] len;
   } word_type;

   // one record per step that yields at least one result
   typedef struct packed {
      logic [WIDX_W-1:0]           n_words;
      logic                        last;
      word_type [NWORDS-1:0]       words;
      logic [CUR_W-1:0]            query_start;
      logic [POS_W-1:0]            ref_start;
      logic [CUR_W-1:0]            query_span;
      logic [CUR_W-1:0]            ref_span;
      logic [CUR_W-1:0]            diag_shift;
      err_type                     error;
   } rec_type;

   typedef struct packed {
      logic              first;
      logic              last;
      logic [CLIP_W-1:0] hard_begin;
      logic [CUR_W-1:0]  lead;
      logic              i_pres;
      logic              i_back;
      logic [CUR_W-1:0]  i_len;
      logic              d_pres;
      logic              d_back;
      logic [CUR_W-1:0]  d_len;
      logic [POS_W-1:0]  run_len;
      logic [CUR_W-1:0]  cur_q;
      logic [CUR_W-1:0]  cur_r;
      logic [CLIP_W-1:0] clean_len;
      logic [CLIP_W-1:0] soft_begin;
      logic [CLIP_W-1:0] soft_end;
      logic [CLIP_W-1:0] hard_end;
      logic [POS_W-1:0]  origin_q;
      logic [POS_W-1:0]  origin_r;
      logic [CUR_W-1:0]  shift;
   } s1_type;

   typedef struct packed {
      logic              first;
      logic              last;
      logic [CLIP_W-1:0] hard_begin;
      logic [CUR_W-1:0]  lead;
      logic              i_pres;
      logic              i_back;
      logic [CUR_W-1:0]  i_len;
      logic              d_pres;
      logic              d_back;
      logic [CUR_W-1:0]  d_len;
      logic [POS_W-1:0]  run_len;
      logic              past_end;
      logic [CUR_W-1:0]  tail;
      logic [CLIP_W-1:0] hard_end;
      logic [CUR_W-1:0]  query_start;
      logic [POS_W-1:0]  ref_start;
      logic [CUR_W-1:0]  query_span;
      logic [CUR_W-1:0]  ref_span;
      logic [CUR_W-1:0]  shift;
   } s2_type;

endpackage

FILE: hw/rtl/arce_front.sv
module arce_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [arce_pkg::IN_W-1:0]    req_tdata,
   input  logic                         req_tuser,
   input  logic                         req_tlast,
   input  logic [arce_pkg::CAP_W-1:0]   cap,
   input  logic [arce_pkg::QCNT_W-1:0]  q_count,
   output logic                         push,
   output arce_pkg::rec_type            rec
);

   localparam int POS_W  = arce_pkg::POS_W;
   localparam int CLIP_W = arce_pkg::CLIP_W;
   localparam int CUR_W  = arce_pkg::CUR_W;
   localparam int CAP_W  = arce_pkg::CAP_W;
   localparam int NW     = arce_pkg::NWORDS;
   localparam int WIDX_W = arce_pkg::WIDX_W;
   localparam int QCNT_W = arce_pkg::QCNT_W;

   logic [POS_W-1:0]  qpos, rpos, rlen;
   logic [CLIP_W-1:0] clean_in, hb_in, sb_in, se_in, he_in;
   logic              first, accept;

   logic [CUR_W-1:0]  cur_q_ff, cur_r_ff, shift_ff;
   logic [POS_W-1:0]  origin_q_ff, origin_r_ff;
   logic [CLIP_W-1:0] clean_ff, sb_ff, se_ff, he_ff;
   logic [CAP_W-1:0]  words_ff;
   arce_pkg::err_type err_ff;

   arce_pkg::s1_type  s1_in, s1_ff;
   arce_pkg::s2_type  s2_in, s2_ff;
   logic              s1_v_ff, s2_v_ff;

   logic [CUR_W:0]    q_diff, r_diff, t_diff;
   logic [CUR_W-1:0]  suffix;
   logic [QCNT_W-1:0] fill;

   assign qpos     = req_tdata[15:0];
   assign rpos     = req_tdata[31:16];
   assign rlen     = req_tdata[47:32];
   assign clean_in = req_tdata[63:48];
   assign hb_in    = req_tdata[79:64];
   assign sb_in    = req_tdata[95:80];
   assign se_in    = req_tdata[111:96];
   assign he_in    = req_tdata[127:112];
   assign first    = req_tuser;

   // queue slots are reserved for every item still in the two stages
   assign fill       = q_count + QCNT_W'(s1_v_ff) + QCNT_W'(s2_v_ff);
   assign req_tready = (fill < arce_pkg::QDEPTH_C);
   assign accept     = req_tvalid && req_tready;

   // stage 1: gaps against the cursors, cursor update
   assign q_diff = {2'b00, qpos} - {1'b0, cur_q_ff};
   assign r_diff = {2'b00, rpos} - {1'b0, cur_r_ff};

   always_comb begin
      s1_in            = '0;
      s1_in.first      = first;
      s1_in.last       = req_tlast;
      s1_in.hard_begin = hb_in;
      s1_in.lead       = {1'b0, sb_in} + {1'b0, qpos};
      s1_in.i_back     = !first && q_diff[CUR_W];
      s1_in.i_pres     = !first && !q_diff[CUR_W] && (q_diff[CUR_W-1:0] != '0);
      s1_in.i_len      = q_diff[CUR_W-1:0];
      s1_in.d_back     = !first && r_diff[CUR_W];
      s1_in.d_pres     = !first && !r_diff[CUR_W] && (r_diff[CUR_W-1:0] != '0);
      s1_in.d_len      = r_diff[CUR_W-1:0];
      s1_in.run_len    = rlen;
      s1_in.cur_q      = {1'b0, qpos} + {1'b0, rlen};
      s1_in.cur_r      = {1'b0, rpos} + {1'b0, rlen};
      s1_in.clean_len  = first ? clean_in : clean_ff;
      s1_in.soft_begin = first ? sb_in : sb_ff;
      s1_in.soft_end   = first ? se_in : se_ff;
      s1_in.hard_end   = first ? he_in : he_ff;
      s1_in.origin_q   = first ? qpos : origin_q_ff;
      s1_in.origin_r   = first ? rpos : origin_r_ff;
      s1_in.shift      = first ? ({1'b0, rpos} - {1'b0, qpos}) : shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         cur_q_ff    <= '0;
         cur_r_ff    <= '0;
         origin_q_ff <= '0;
         origin_r_ff <= '0;
         shift_ff    <= '0;
         clean_ff    <= '0;
         sb_ff       <= '0;
         se_ff       <= '0;
         he_ff       <= '0;
      end else begin
         s1_v_ff <= accept;
         if (accept) begin
            cur_q_ff    <= s1_in.cur_q;
            cur_r_ff    <= s1_in.cur_r;
            origin_q_ff <= s1_in.origin_q;
            origin_r_ff <= s1_in.origin_r;
            shift_ff    <= s1_in.shift;
            clean_ff    <= s1_in.clean_len;
            sb_ff       <= s1_in.soft_begin;
            se_ff       <= s1_in.soft_end;
            he_ff       <= s1_in.hard_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: trailing soft clip and summary
   assign t_diff = {2'b00, s1_ff.clean_len} - {1'b0, s1_ff.cur_q};
   assign suffix = t_diff[CUR_W] ? '0 : t_diff[CUR_W-1:0];

   always_comb begin
      s2_in             = '0;
      s2_in.first       = s1_ff.first;
      s2_in.last        = s1_ff.last;
      s2_in.hard_begin  = s1_ff.hard_begin;
      s2_in.lead        = s1_ff.lead;
      s2_in.i_pres      = s1_ff.i_pres;
      s2_in.i_back      = s1_ff.i_back;
      s2_in.i_len       = s1_ff.i_len;
      s2_in.d_pres      = s1_ff.d_pres;
      s2_in.d_back      = s1_ff.d_back;
      s2_in.d_len       = s1_ff.d_len;
      s2_in.run_len     = s1_ff.run_len;
      s2_in.past_end    = t_diff[CUR_W];
      s2_in.tail        = {1'b0, s1_ff.soft_end} + suffix;
      s2_in.hard_end    = s1_ff.hard_end;
      s2_in.query_start = {1'b0, s1_ff.origin_q} + {1'b0, s1_ff.soft_begin};
      s2_in.ref_start   = s1_ff.origin_r;
      s2_in.query_span  = s1_ff.cur_q - {1'b0, s1_ff.origin_q};
      s2_in.ref_span    = s1_ff.cur_r - {1'b0, s1_ff.origin_r};
      s2_in.shift       = s1_ff.shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: capacity, first error of the read, word packing
   logic [NW-1:0]          pres, kept;
   arce_pkg::word_type     cand [NW];
   logic [CAP_W-1:0]       words_base, words_in, avail;
   logic [WIDX_W-1:0]      avail3, rank, slot;
   arce_pkg::err_type      ev [NW+1];
   arce_pkg::err_type      step_err, err_base, err_in;
   arce_pkg::rec_type      rec_c;

   always_comb begin
      pres[0]     = s2_ff.first ? (s2_ff.hard_begin != '0) : s2_ff.i_pres;
      cand[0].op  = s2_ff.first ? arce_pkg::OP_H : arce_pkg::OP_I;
      cand[0].len = s2_ff.first ? {1'b0, s2_ff.hard_begin} : s2_ff.i_len;
      pres[1]     = s2_ff.first ? (s2_ff.lead != '0) : s2_ff.d_pres;
      cand[1].op  = s2_ff.first ? arce_pkg::OP_S : arce_pkg::OP_D;
      cand[1].len = s2_ff.first ? s2_ff.lead : s2_ff.d_len;
      pres[2]     = (s2_ff.run_len != '0);
      cand[2].op  = arce_pkg::OP_M;
      cand[2].len = {1'b0, s2_ff.run_len};
      pres[3]     = s2_ff.last && (s2_ff.tail != '0);
      cand[3].op  = arce_pkg::OP_S;
      cand[3].len = s2_ff.tail;
      pres[4]     = s2_ff.last && (s2_ff.hard_end != '0);
      cand[4].op  = arce_pkg::OP_H;
      cand[4].len = {1'b0, s2_ff.hard_end};
   end

   assign words_base = s2_ff.first ? '0 : words_ff;
   assign avail      = (cap > words_base) ? (cap - words_base) : '0;
   assign avail3     = (avail > CAP_W'(NW)) ? WIDX_W'(NW) : avail[WIDX_W-1:0];

   always_comb begin
      rank  = '0;
      slot  = '0;
      rec_c = '0;
      for (int i = 0; i < NW; i++) begin
         kept[i] = pres[i] && (rank < avail3);
         if (pres[i]) begin
            rank = rank + WIDX_W'(1);
         end
         if (kept[i]) begin
            rec_c.words[slot] = cand[i];
            slot = slot + WIDX_W'(1);
         end
      end
      rec_c.n_words     = slot;
      rec_c.last        = s2_ff.last;
      rec_c.query_start = s2_ff.query_start;
      rec_c.ref_start   = s2_ff.ref_start;
      rec_c.query_span  = s2_ff.query_span;
      rec_c.ref_span    = s2_ff.ref_span;
      rec_c.diag_shift  = s2_ff.shift;
      rec_c.error       = err_in;
   end

   // flag events in the order the read would raise them
   always_comb begin
      ev[0] = s2_ff.i_back ? arce_pkg::ERR_BACK :
              (pres[0] && !kept[0]) ? arce_pkg::ERR_FULL : arce_pkg::ERR_NONE;
      ev[1] = s2_ff.d_back ? arce_pkg::ERR_BACK :
              (pres[1] && !kept[1]) ? arce_pkg::ERR_FULL : arce_pkg::ERR_NONE;
      ev[2] = (pres[2] && !kept[2]) ? arce_pkg::ERR_FULL : arce_pkg::ERR_NONE;
      ev[3] = (s2_ff.last && s2_ff.past_end) ? arce_pkg::ERR_PAST_END : arce_pkg::ERR_NONE;
      ev[4] = (pres[3] && !kept[3]) ? arce_pkg::ERR_FULL : arce_pkg::ERR_NONE;
      ev[5] = (pres[4] && !kept[4]) ? arce_pkg::ERR_FULL : arce_pkg::ERR_NONE;
      step_err = arce_pkg::ERR_NONE;
      for (int i = NW; i >= 0; i--) begin
         if (ev[i] != arce_pkg::ERR_NONE) begin
            step_err = ev[i];
         end
      end
   end

   assign err_base = s2_ff.first ? arce_pkg::ERR_NONE : err_ff;
   assign err_in   = (err_base != arce_pkg::ERR_NONE) ? err_base : step_err;
   assign words_in = words_base + CAP_W'(slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= '0;
         err_ff   <= arce_pkg::ERR_NONE;
      end else if (s2_v_ff) begin
         words_ff <= words_in;
         err_ff   <= err_in;
      end
   end

   assign push = s2_v_ff && ((slot != '0) || s2_ff.last);
   assign rec  = rec_c;

endmodule

FILE: hw/rtl/arce_queue.sv
module arce_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  arce_pkg::rec_type            push_rec,
   input  logic                         pop,
   output logic                         head_valid,
   output arce_pkg::rec_type            head_rec,
   output logic [arce_pkg::QCNT_W-1:0]  count
);

   localparam int QPTR_W = arce_pkg::QPTR_W;
   localparam int QCNT_W = arce_pkg::QCNT_W;

   arce_pkg::rec_type   mem_ff [arce_pkg::QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_rec   = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

FILE: hw/rtl/arce_back.sv
module arce_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  arce_pkg::rec_type             head_rec,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [arce_pkg::OUT_W-1:0]    rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int WIDX_W = arce_pkg::WIDX_W;
   localparam int LEN_W  = arce_pkg::WORD_LEN_W;

   logic [WIDX_W-1:0]            k_ff, n_res;
   logic                         rsp_v_ff, user_ff, last_ff;
   logic [arce_pkg::OUT_W-1:0]   data_ff, data_in;
   logic                         load, is_final, has, done;
   arce_pkg::word_type           word;

   assign n_res    = (head_rec.n_words == '0) ? WIDX_W'(1) : head_rec.n_words;
   assign is_final = (k_ff == n_res - WIDX_W'(1));
   assign load     = head_valid && (!rsp_v_ff || rsp_tready);
   assign pop      = load && is_final;
   assign has      = (k_ff < head_rec.n_words);
   assign done     = head_rec.last && is_final;
   assign word     = head_rec.words[k_ff];

   always_comb begin
      data_in          = '0;
      data_in[3:0]     = has ? word.op : 4'd0;
      data_in[31:4]    = has ? LEN_W'(word.len) : '0;
      data_in[48:32]   = done ? head_rec.query_start : '0;
      data_in[64:49]   = done ? head_rec.ref_start : '0;
      data_in[81:65]   = done ? head_rec.query_span : '0;
      data_in[98:82]   = done ? head_rec.ref_span : '0;
      data_in[115:99]  = done ? head_rec.diag_shift : '0;
      data_in[117:116] = head_rec.error;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         if (load) begin
            rsp_v_ff <= 1'b1;
            k_ff     <= is_final ? '0 : k_ff + WIDX_W'(1);
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= has;
         last_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: hw/rtl/aligned_runs_to_cigar_encoder_unit.sv
// Turns the aligned runs of a read into SAM CIGAR words.
// req: one run per transfer. tlast marks the read's last run, tuser its first
//   run; tdata carries the run and, on a first run, the clip lengths.
// rsp: one CIGAR word per transfer. tuser is high when the transfer carries a
//   word; tlast marks the final transfer of a read, which also carries the
//   alignment start, spans and diagonal shift. The read's error code is in
//   every transfer.
// csr: write of the per-read word capacity (reset 1023), taken at once.
// Throughput: one result per cycle while rsp is not stalled; a run gives up
// to 3 results (up to 5 on a last run), and the single-word output register
// sets this rate. A run that yields no word gives no result unless it is
// the read's last run.
// Reset clears all read state and empties the 4-entry queue between the
// classifying front and the word serializer. When rsp stalls the queue
// fills and req_tready drops; the front stages never hold an item.
module aligned_runs_to_cigar_encoder_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // query_pos, ref_pos, run_len, clean_len, hard_begin, soft_begin,
   // soft_end, hard_end
   input  logic [arce_pkg::IN_W-1:0]    req_tdata,
   // first_run
   input  logic                         req_tuser,
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // cigar_op, cigar_len, query_start, ref_start, query_span, ref_span,
   // diag_shift, error
   output logic [arce_pkg::OUT_W-1:0]   rsp_tdata,
   // has_op
   output logic                         rsp_tuser,
   output logic                         rsp_tlast,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [arce_pkg::CAP_W-1:0]   csr_wdata
);

   logic [arce_pkg::CAP_W-1:0]   cap_ff;
   logic                         q_push, q_pop, q_valid;
   arce_pkg::rec_type            q_in, q_head;
   logic [arce_pkg::QCNT_W-1:0]  q_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= arce_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_wdata;
      end
   end

   arce_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cap        (cap_ff),
      .q_count    (q_count),
      .push       (q_push),
      .rec        (q_in)
   );

   arce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (q_in),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_rec   (q_head),
      .count      (q_count)
   );

   arce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_rec   (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // the reservation in the front must keep the queue from overrunning
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < arce_pkg::QDEPTH_C))
      else $error("record queue overrun");

   a_empty_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("result without a word that does not close a read");

   a_op_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[3:0] == arce_pkg::OP_M) || (rsp_tdata[3:0] == arce_pkg::OP_I) ||
         (rsp_tdata[3:0] == arce_pkg::OP_D) || (rsp_tdata[3:0] == arce_pkg::OP_S) ||
         (rsp_tdata[3:0] == arce_pkg::OP_H))
      else $error("bad CIGAR op code");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty record queue");

endmodule
